[src/iol_pkg.sv]
package iol_pkg;

  // List capacity and derived widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned GRP_SZ   = 8;
  localparam int unsigned NGRP     = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

  typedef enum logic [2:0] {
    OP_READ = 3'd0,
    OP_HEAD = 3'd1,
    OP_TAIL = 3'd2,
    OP_AT   = 3'd3,
    OP_DEL  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    C_HOLD = 2'd0,
    C_INS  = 2'd1,
    C_DEL  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [2:0]              func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } iol_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [OUT_CNT_W-1:0]    count_after;
  } iol_out_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e                op;
    logic                    rd_en;
    logic [CMP_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

[src/iol_if.sv]
interface iol_in_if;
  import iol_pkg::*;
  logic    valid;
  logic    ready;
  iol_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iol_out_if;
  import iol_pkg::*;
  logic     valid;
  logic     ready;
  iol_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/iol_cell.sv]
module iol_cell
  import iol_pkg::*;
(
  input  logic                    clk_i,
  input  logic [IDX_W-1:0]        idx_i,
  input  cell_ctl_t               ctl_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] data_o,
  output logic signed [VAL_W-1:0] rd_o
);

  logic signed [VAL_W-1:0] data_q, data_d;
  logic [CMP_W-1:0]        idx_ext;

  assign idx_ext = CMP_W'(idx_i);

  // Shift up on insert, shift down on delete, hold otherwise
  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      C_INS: begin
        if (idx_ext > ctl_i.pos) begin
          data_d = left_i;
        end else if (idx_ext == ctl_i.pos) begin
          data_d = ctl_i.value;
        end
      end
      C_DEL: begin
        if (idx_ext >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Drive own value onto the read tree only when addressed
  assign rd_o   = (ctl_i.rd_en && (idx_ext == ctl_i.pos)) ? data_q : '0;

endmodule

[src/iol_chain.sv]
module iol_chain
  import iol_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    fire_i,
  input  cell_ctl_t               ctl_i,
  output logic [VAL_W-1:0]        grp_o [NGRP]
);

  logic signed [VAL_W-1:0] data [CAPACITY];
  logic signed [VAL_W-1:0] rd   [CAPACITY];
  logic [VAL_W-1:0]        grp_d [NGRP];
  logic [VAL_W-1:0]        grp_q [NGRP];

  // Row of slot cells, slot 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = ctl_i.value;
    end else begin : g_mid_l
      assign left = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = data[i];
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    iol_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctl_i   (ctl_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[i]),
      .rd_o    (rd[i])
    );
  end

  // First level of the read tree: OR groups of eight cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GRP_SZ; j++) begin
        if (g * GRP_SZ + j < CAPACITY) begin
          grp_d[g] = grp_d[g] | rd[g * GRP_SZ + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

[src/indexed_ordered_list_top.sv]
// Indexed ordered list: up to CAPACITY signed 32-bit values kept in position
// order in a row of slot cells (slot 0 is the head).
// Input channel in_i carries func, position and value; output channel out_o
// returns read_value, status and count_after, one result per transfer in.
// Operations: read, insert at head, insert at tail, insert at position and
// delete at position. Inserts shift later slots up, deletes shift them down,
// all cells moving in the same cycle as the input transfer.
// A result goes through the middle stage, then the output register. The read
// goes through a two-level OR tree over the cells, registered once per level.
// Throughput: one item per cycle while out_o is taken.
// If the receiver stalls, the result holds in the output register and one
// more item finishes into the middle stage; in_i.ready then drops.
// Reset clears the entry count and all valid flags; the slot contents are not
// cleared and are never visible, since only positions below the count are read.
module indexed_ordered_list_top
  import iol_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  iol_in_if.sink    in_i,
  iol_out_if.source out_o
);

  typedef struct packed {
    logic                 nf;
    status_e              status;
    logic [CNT_W-1:0]     count;
  } mid_t;

  logic [CNT_W-1:0] count_q, count_d;
  logic             mid_v_q;
  mid_t             mid_q, mid_d;
  logic             out_v_q;
  iol_out_t         out_q;
  logic             fire, mid_move;
  cell_ctl_t        ctl, ctl_cmd;
  logic [CMP_W-1:0] cnt_ext, pos_ext, ins_pos;
  logic [VAL_W-1:0] grp [NGRP];
  logic [VAL_W-1:0] rd_or;

  assign mid_move   = mid_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !mid_v_q || mid_move;
  assign fire       = in_i.valid && in_i.ready;

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(in_i.data.position);

  // Decode the operation against the current count
  always_comb begin
    ctl_cmd.op    = C_HOLD;
    ctl_cmd.rd_en = 1'b0;
    ctl_cmd.pos   = pos_ext;
    ctl_cmd.value = in_i.data.value;
    mid_d.nf      = 1'b0;
    mid_d.status  = ST_DONE;
    count_d       = count_q;
    ins_pos       = pos_ext;
    unique case (op_e'(in_i.data.func))
      OP_READ: begin
        if (pos_ext < cnt_ext) begin
          ctl_cmd.rd_en = 1'b1;
        end else begin
          mid_d.nf     = 1'b1;
          mid_d.status = ST_RANGE;
        end
      end
      OP_HEAD, OP_TAIL, OP_AT: begin
        priority if (op_e'(in_i.data.func) == OP_HEAD) begin
          ins_pos = '0;
        end else if (op_e'(in_i.data.func) == OP_TAIL) begin
          ins_pos = cnt_ext;
        end else begin
          ins_pos = pos_ext;
        end
        priority if (ins_pos > cnt_ext) begin
          mid_d.status = ST_RANGE;
        end else if (count_q == CNT_W'(CAPACITY)) begin
          mid_d.status = ST_FULL;
        end else begin
          ctl_cmd.op  = C_INS;
          ctl_cmd.pos = ins_pos;
          count_d     = count_q + 1'b1;
        end
      end
      OP_DEL: begin
        if (pos_ext < cnt_ext) begin
          ctl_cmd.op = C_DEL;
          count_d    = count_q - 1'b1;
        end else begin
          mid_d.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    mid_d.count = count_d;
  end

  // Cells act only on an input transfer
  always_comb begin
    ctl    = ctl_cmd;
    ctl.op = fire ? ctl_cmd.op : C_HOLD;
  end

  iol_chain u_chain (
    .clk_i  (clk_i),
    .fire_i (fire),
    .ctl_i  (ctl),
    .grp_o  (grp)
  );

  // Second level of the read tree
  always_comb begin
    rd_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_or = rd_or | grp[g];
    end
  end

  // Advance count, middle stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q <= count_d;
      end
      if (fire) begin
        mid_v_q <= 1'b1;
      end else if (mid_move) begin
        mid_v_q <= 1'b0;
      end
      if (mid_move) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mid_q <= mid_d;
    end
    if (mid_move) begin
      out_q.read_value  <= mid_q.nf ? '1 : $signed(rd_or);
      out_q.status      <= mid_q.status;
      out_q.count_after <= OUT_CNT_W'(mid_q.count);
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctl.op == C_INS) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the count");

  a_delete_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctl.op == C_DEL) |=> (count_q == $past(count_q) - 1'b1))
    else $error("delete did not shrink the count");

  a_notfound_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_v_q && mid_q.nf) |-> (mid_q.status == ST_RANGE))
    else $error("not-found read without range status");

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iol_pkg::*;

  localparam int unsigned RUN_LIMIT  = 200000;
  localparam int unsigned TAIL_WAIT  = 8;
  localparam int unsigned PRINT_MAX  = 20;

  logic clk_i;
  logic rst_ni;

  iol_in_if  in_ch ();
  iol_out_if out_ch ();

  indexed_ordered_list_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the list, head at index 0
  logic signed [VAL_W-1:0] list_model[$];
  // Results still owed by the block, oldest first
  iol_out_t                expected_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned err_count     = 0;
  int unsigned result_cnt    = 0;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Count cycles for the run limit
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Apply one operation to the shadow list and return what the block should report
  function automatic iol_out_t apply_list_op(iol_in_t item);
    iol_out_t res;
    int       cnt;
    int       ins_pos;
    bit       is_ins;
    cnt            = list_model.size();
    res.read_value = '0;
    res.status     = ST_DONE;
    is_ins         = 1'b0;
    ins_pos        = 0;
    case (item.func)
      OP_READ: begin
        if (int'(item.position) < cnt) begin
          res.read_value = list_model[item.position];
        end else begin
          res.read_value = -1;
          res.status     = ST_RANGE;
        end
      end
      OP_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = 0;
      end
      OP_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt;
      end
      OP_AT: begin
        is_ins  = 1'b1;
        ins_pos = int'(item.position);
      end
      OP_DEL: begin
        if (int'(item.position) < cnt) list_model.delete(int'(item.position));
        else res.status = ST_RANGE;
      end
      default: ;
    endcase
    // Range check wins over the full check
    if (is_ins) begin
      if (ins_pos > cnt) res.status = ST_RANGE;
      else if (cnt >= int'(CAPACITY)) res.status = ST_FULL;
      else list_model.insert(ins_pos, item.value);
    end
    res.count_after = OUT_CNT_W'(list_model.size());
    return res;
  endfunction

  // Offer one operation, hold it until the transfer, then record the expected result
  task automatic send_op(logic [2:0] func, logic [POS_W-1:0] pos, logic [VAL_W-1:0] value);
    iol_in_t item;
    item.func     = func;
    item.position = pos;
    item.value    = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_results.push_back(apply_list_op(item));
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < PRINT_MAX)
      $display("mismatch on result %0d: %s got %h want %h", result_cnt, what, got, want);
    err_count++;
  endtask

  // Receiver: random back-pressure, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    iol_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.data.read_value, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.read_value !== want.read_value)
          report_mismatch("read_value", out_ch.data.read_value, want.read_value);
        if (out_ch.data.status !== want.status)
          report_mismatch("status", 32'(out_ch.data.status), 32'(want.status));
        if (out_ch.data.count_after !== want.count_after)
          report_mismatch("count_after", 32'(out_ch.data.count_after), 32'(want.count_after));
      end
      result_cnt++;
    end
  end

  // Value with the extremes mixed in
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Position mostly near the live range, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] pick_pos(int span);
    if ($urandom_range(99) < 15) return POS_W'($urandom_range(255));
    return POS_W'($urandom_range(span));
  endfunction

  // Edges of every field and each corner case, starting from an empty list
  task automatic test_directed();
    send_op(OP_READ, 8'd0, 32'h0);
    send_op(OP_READ, 8'd255, 32'h0);
    send_op(OP_DEL, 8'd0, 32'h0);
    send_op(OP_AT, 8'd1, 32'h1111_1111);
    send_op(OP_AT, 8'd0, 32'h7fff_ffff);
    send_op(OP_HEAD, 8'd0, 32'h8000_0000);
    send_op(OP_TAIL, 8'd0, 32'hffff_ffff);
    send_op(OP_TAIL, 8'd255, 32'h0000_0000);
    send_op(OP_AT, 8'd2, 32'h1234_5678);
    send_op(OP_AT, 8'd5, 32'h5a5a_5a5a);
    send_op(OP_AT, 8'd7, 32'ha5a5_a5a5);
    send_op(OP_READ, 8'd0, 32'h0);
    send_op(OP_READ, 8'd2, 32'h0);
    send_op(OP_READ, 8'd5, 32'hffff_ffff);
    send_op(OP_READ, 8'd6, 32'h0);
    send_op(OP_DEL, 8'd5, 32'h0);
    send_op(OP_DEL, 8'd0, 32'h0);
    send_op(OP_DEL, 8'd255, 32'hffff_ffff);
    // Unused function codes change nothing
    for (int f = int'(OP_DEL) + 1; f < 8; f++) send_op(3'(f), 8'd255, 32'hffff_ffff);
    send_op(OP_READ, 8'd255, 32'h0);
    send_op(OP_READ, 8'd3, 32'h0);
  endtask

  // Fill to capacity, poke at the full list, then empty it again
  task automatic test_full_list();
    int cnt;
    while (list_model.size() < int'(CAPACITY)) begin
      cnt = list_model.size();
      case ($urandom_range(2))
        0:       send_op(OP_HEAD, POS_W'($urandom_range(255)), pick_value());
        1:       send_op(OP_TAIL, POS_W'($urandom_range(255)), pick_value());
        default: send_op(OP_AT, POS_W'($urandom_range(cnt)), pick_value());
      endcase
    end
    send_op(OP_HEAD, 8'd0, pick_value());
    send_op(OP_TAIL, 8'd0, pick_value());
    send_op(OP_AT, POS_W'(CAPACITY), pick_value());
    send_op(OP_AT, POS_W'(CAPACITY + 1), pick_value());
    send_op(OP_AT, 8'd255, pick_value());
    send_op(OP_READ, POS_W'(CAPACITY - 1), 32'h0);
    send_op(OP_READ, POS_W'(CAPACITY), 32'h0);
    send_op(OP_DEL, POS_W'(CAPACITY), 32'h0);
    send_op(OP_DEL, POS_W'(CAPACITY - 1), 32'h0);
    send_op(OP_TAIL, 8'd0, pick_value());
    // Drain with deletes at random live positions
    while (list_model.size() > 0) begin
      cnt = list_model.size();
      send_op(OP_DEL, POS_W'($urandom_range(cnt - 1)), 32'h0);
    end
    send_op(OP_READ, 8'd0, 32'h0);
    send_op(OP_DEL, 8'd0, 32'h0);
  endtask

  // Random walk of the list length, alternating between growing and shrinking
  task automatic test_random(int n);
    int          cnt;
    int unsigned sel;
    int unsigned ins_w;
    bit          grow;
    for (int i = 0; i < n; i++) begin
      grow  = ((i / 150) % 2) == 0;
      ins_w = grow ? 50 : 25;
      cnt   = list_model.size();
      sel   = $urandom_range(99);
      if (sel < 5) begin
        send_op(3'($urandom_range(7, int'(OP_DEL) + 1)), POS_W'($urandom_range(255)),
                $urandom());
      end else if (sel < 25) begin
        send_op(OP_READ, pick_pos(cnt), $urandom());
      end else if (sel < 25 + ins_w) begin
        case ($urandom_range(2))
          0:       send_op(OP_HEAD, POS_W'($urandom_range(255)), pick_value());
          1:       send_op(OP_TAIL, POS_W'($urandom_range(255)), pick_value());
          default: send_op(OP_AT, pick_pos(cnt), pick_value());
        endcase
      end else begin
        send_op(OP_DEL, pick_pos(cnt), $urandom());
      end
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  task automatic test_output_stall();
    int unsigned saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    stall_left    = 80;
    test_random(40);
    send_idle_pct = saved_idle;
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_ni       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    recv_idle_pct = 48;
    test_directed();
    test_full_list();
    test_random(350);

    send_idle_pct = 48;
    recv_idle_pct = 26;
    test_random(350);
    test_output_stall();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350);
    test_full_list();

    // Drop valid and wait for the last results, then a few quiet cycles
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (err_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
